### src/vfsd_pkg.sv
package vfsd_pkg;

    // config register select (paddr[2])
    localparam logic REG_MASS = 1'b0;
    localparam logic REG_ZTOL = 1'b1;

    localparam logic [30:0] MASS_RST = 31'd32768000;
    localparam logic [16:0] ZTOL_RST = 17'd1;

    localparam logic signed [31:0] UNLIMITED = -32'sd65536;

    // divider: 48-bit numerator, 32-bit denominator, 32 quotient bits
    localparam int DIV_NW  = 48;
    localparam int DIV_QW  = 32;
    localparam int DIV_LAT = DIV_QW + 2;

    // square root of {len, 17'b0}: 25 result bits, 27-bit remainder
    localparam int SQ_RW  = 25;
    localparam int SQ_XW  = 2 * SQ_RW;
    localparam int SQ_REMW = SQ_RW + 2;
    localparam int SQ_LAT = SQ_RW + 1;

    localparam int ROOT_DLY = DIV_LAT - SQ_LAT;
    localparam int IDL_DLY  = 2 * DIV_LAT;
    localparam int SIDE_DLY = 3 * DIV_LAT;
    localparam int LEN_TAP  = 2 * DIV_LAT - 1;
    localparam int PIPE_LAT = 3 * DIV_LAT + 5;

    typedef struct packed {
        logic [31:0]        len;
        logic signed [31:0] match;
        logic               rem_neg;
        logic               zero_hit;
        logic               unl;
        logic               dist_neg;
    } t_side;

    function automatic logic signed [31:0] sat_s32(input logic signed [48:0] v);
        logic hi_same;
        hi_same = (&v[48:31]) || !(|v[48:31]);
        if (hi_same) begin
            return v[31:0];
        end else if (v[48]) begin
            return 32'sh8000_0000;
        end else begin
            return 32'sh7FFF_FFFF;
        end
    endfunction

    // signed, saturated quotient from magnitude and overflow flag
    function automatic logic signed [31:0] qsat(input logic neg, input logic nz,
                                                input logic ovf,
                                                input logic [DIV_QW-1:0] q);
        logic big;
        big = ovf || q[DIV_QW-1];
        if (nz) begin
            return '0;
        end else if (!neg) begin
            return big ? 32'sh7FFF_FFFF : $signed(q);
        end else begin
            return big ? 32'sh8000_0000 : $signed(-q);
        end
    endfunction

endpackage

### src/vfsd_div.sv
module vfsd_div (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [vfsd_pkg::DIV_NW-1:0]   i_num,
    input  logic [vfsd_pkg::DIV_QW-1:0]   i_den,
    input  logic                          i_neg,
    input  logic                          i_nz,
    output logic signed [31:0]            o_quo
);
    import vfsd_pkg::*;

    logic [DIV_QW-1:0] r_rem [0:DIV_QW];
    logic [DIV_QW-1:0] r_low [0:DIV_QW];
    logic [DIV_QW-1:0] r_den [0:DIV_QW];
    logic [DIV_QW-1:0] r_quo [0:DIV_QW];
    logic              r_ovf [0:DIV_QW];
    logic              r_neg [0:DIV_QW];
    logic              r_nz  [0:DIV_QW];
    logic signed [31:0] r_out;

    logic [DIV_QW-1:0] n_rem [0:DIV_QW-1];
    logic              n_ge  [0:DIV_QW-1];

    always_comb begin
        for (int s = 0; s < DIV_QW; s++) begin
            logic [DIV_QW:0] trial;
            trial = {r_rem[s], r_low[s][DIV_QW-1-s]};
            n_ge[s] = trial >= {1'b0, r_den[s]};
            n_rem[s] = n_ge[s] ? DIV_QW'(trial - {1'b0, r_den[s]}) : trial[DIV_QW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // a quotient of 2^31 or more saturates (r_ovf flags 2^32 or more)
            r_rem[0] <= DIV_QW'(i_num[DIV_NW-1:DIV_QW]);
            r_low[0] <= i_num[DIV_QW-1:0];
            r_den[0] <= i_den;
            r_quo[0] <= '0;
            r_ovf[0] <= DIV_QW'(i_num[DIV_NW-1:DIV_QW]) >= i_den;
            r_neg[0] <= i_neg;
            r_nz[0]  <= i_nz;
            for (int s = 0; s < DIV_QW; s++) begin
                r_rem[s+1] <= n_rem[s];
                r_low[s+1] <= r_low[s];
                r_den[s+1] <= r_den[s];
                r_quo[s+1] <= {r_quo[s][DIV_QW-2:0], n_ge[s]};
                r_ovf[s+1] <= r_ovf[s];
                r_neg[s+1] <= r_neg[s];
                r_nz[s+1]  <= r_nz[s];
            end
            r_out <= qsat(r_neg[DIV_QW], r_nz[DIV_QW], r_ovf[DIV_QW], r_quo[DIV_QW]);
        end
    end

    assign o_quo = r_out;

endmodule

### src/vfsd_sqrt.sv
module vfsd_sqrt (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [31:0]                 i_len,
    output logic [vfsd_pkg::SQ_RW-1:0]  o_root
);
    import vfsd_pkg::*;

    logic [SQ_XW-1:0]   r_x    [0:SQ_RW];
    logic [SQ_REMW-1:0] r_rem  [0:SQ_RW];
    logic [SQ_RW-1:0]   r_root [0:SQ_RW];

    logic [SQ_REMW-1:0] n_rem  [0:SQ_RW-1];
    logic               n_ge   [0:SQ_RW-1];

    // one result bit per stage, top bit pair first
    always_comb begin
        for (int i = 0; i < SQ_RW; i++) begin
            logic [SQ_REMW+1:0] acc;
            logic [SQ_REMW+1:0] trial;
            acc   = {r_rem[i], r_x[i][2*(SQ_RW-1-i) +: 2]};
            trial = (SQ_REMW+2)'({r_root[i], 2'b01});
            n_ge[i]  = acc >= trial;
            n_rem[i] = n_ge[i] ? SQ_REMW'(acc - trial) : acc[SQ_REMW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= SQ_XW'({i_len, 17'b0});
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            for (int i = 0; i < SQ_RW; i++) begin
                r_x[i+1]    <= r_x[i];
                r_rem[i+1]  <= n_rem[i];
                r_root[i+1] <= {r_root[i][SQ_RW-2:0], n_ge[i]};
            end
        end
    end

    assign o_root = r_root[SQ_RW];

endmodule

### src/vfsd_axis.sv
module vfsd_axis (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [31:0] i_dist,
    input  logic signed [31:0] i_lpos,
    input  logic signed [31:0] i_lneg,
    input  logic signed [31:0] i_match,
    input  logic [30:0]        i_ft,
    input  logic [30:0]        i_mass,
    input  logic [16:0]        i_ztol,
    output logic signed [31:0] o_vel
);
    import vfsd_pkg::*;

    // stage A: product
    logic signed [31:0] r_a_dist, r_a_lpos, r_a_lneg, r_a_match;
    logic [30:0]        r_a_ft;
    logic signed [63:0] r_a_prod;
    logic signed [63:0] n_a_prod;

    // stage B: remainder
    logic signed [31:0] r_b_rem, r_b_dist, r_b_lpos, r_b_lneg, r_b_match;
    logic [30:0]        r_b_ft;
    logic signed [48:0] n_b_diff;

    // stage C: magnitudes and limit choice
    t_side              r_c_side, n_c_side;
    logic [31:0]        r_c_dabs, r_c_rabs;
    logic [30:0]        r_c_ft;
    logic               r_c_rneg, r_c_rz, r_c_dz;
    logic signed [31:0] n_c_restr;
    logic               n_c_pos;

    logic signed [31:0] w_idl, w_acc, w_tim, w_max;
    logic [SQ_RW-1:0]   w_root;
    logic [31:0]        w_acc_abs, w_tim_abs, w_len;

    logic [SQ_RW-1:0]   r_root [0:ROOT_DLY-1];
    logic signed [31:0] r_idl  [0:IDL_DLY-1];
    t_side              r_side [0:SIDE_DLY-1];

    // stage G / H
    t_side              w_side;
    logic signed [31:0] w_ideal, w_min;
    logic signed [32:0] r_g_val, n_g_val;
    logic signed [31:0] r_g_match;
    logic               r_g_zero, r_g_add;
    logic signed [31:0] r_h_vel;
    logic signed [33:0] w_sum;

    assign n_a_prod = $signed(i_match) * $signed({1'b0, i_ft});
    assign n_b_diff = 49'(r_a_dist) - 49'($signed(r_a_prod[63:16]));

    always_comb begin
        n_c_pos   = !r_b_rem[31] && (r_b_rem != 32'sd0);
        n_c_restr = n_c_pos ? r_b_lpos : r_b_lneg;
        n_c_side.len      = r_b_rem[31] ? 32'(-r_b_rem) : 32'(r_b_rem);
        n_c_side.match    = r_b_match;
        n_c_side.rem_neg  = r_b_rem[31];
        n_c_side.zero_hit = n_c_side.len < {15'b0, i_ztol};
        n_c_side.unl      = n_c_restr == UNLIMITED;
        n_c_side.dist_neg = r_b_dist[31];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_dist  <= i_dist;
            r_a_lpos  <= i_lpos;
            r_a_lneg  <= i_lneg;
            r_a_match <= i_match;
            r_a_ft    <= i_ft;
            r_a_prod  <= n_a_prod;

            r_b_rem   <= sat_s32(n_b_diff);
            r_b_dist  <= r_a_dist;
            r_b_lpos  <= r_a_lpos;
            r_b_lneg  <= r_a_lneg;
            r_b_match <= r_a_match;
            r_b_ft    <= r_a_ft;

            r_c_side  <= n_c_side;
            r_c_dabs  <= r_b_dist[31] ? 32'(-r_b_dist) : 32'(r_b_dist);
            r_c_dz    <= r_b_dist == 32'sd0;
            r_c_rabs  <= n_c_restr[31] ? 32'(-n_c_restr) : 32'(n_c_restr);
            r_c_rneg  <= n_c_restr[31];
            r_c_rz    <= n_c_restr == 32'sd0;
            r_c_ft    <= r_b_ft;
        end
    end

    vfsd_div u_div_idl (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_num ({r_c_dabs, 16'h0}),
        .i_den ({1'b0, r_c_ft}),
        .i_neg (1'b0),
        .i_nz  (r_c_dz),
        .o_quo (w_idl)
    );

    vfsd_div u_div_acc (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_num ({r_c_rabs, 16'h0}),
        .i_den ({1'b0, i_mass}),
        .i_neg (r_c_rneg),
        .i_nz  (r_c_rz),
        .o_quo (w_acc)
    );

    vfsd_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_len  (r_c_side.len),
        .o_root (w_root)
    );

    assign w_acc_abs = w_acc[31] ? 32'(-w_acc) : 32'(w_acc);

    vfsd_div u_div_tim (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_num (DIV_NW'({r_root[ROOT_DLY-1], 16'h0})),
        .i_den (w_acc_abs),
        .i_neg (w_acc[31]),
        .i_nz  (r_root[ROOT_DLY-1] == '0),
        .o_quo (w_tim)
    );

    assign w_tim_abs = w_tim[31] ? 32'(-w_tim) : 32'(w_tim);
    assign w_len     = r_side[LEN_TAP].len;

    vfsd_div u_div_max (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_num ({w_len, 16'h0}),
        .i_den (w_tim_abs),
        .i_neg (w_tim[31]),
        .i_nz  (w_len == 32'd0),
        .o_quo (w_max)
    );

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_root[0] <= w_root;
            for (int k = 1; k < ROOT_DLY; k++) r_root[k] <= r_root[k-1];
            r_idl[0] <= w_idl;
            for (int k = 1; k < IDL_DLY; k++) r_idl[k] <= r_idl[k-1];
            r_side[0] <= r_c_side;
            for (int k = 1; k < SIDE_DLY; k++) r_side[k] <= r_side[k-1];
        end
    end

    assign w_side  = r_side[SIDE_DLY-1];
    assign w_ideal = r_idl[IDL_DLY-1];
    assign w_min   = (w_ideal < w_max) ? w_ideal : w_max;

    always_comb begin
        if (w_side.unl) begin
            n_g_val = w_side.dist_neg ? -33'(w_ideal) : 33'(w_ideal);
        end else begin
            n_g_val = w_side.rem_neg ? -33'(w_min) : 33'(w_min);
        end
    end

    // unlimited path does not add the match velocity
    assign w_sum = 34'(r_g_val) + (r_g_add ? 34'(r_g_match) : 34'sd0);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_g_val   <= n_g_val;
            r_g_match <= w_side.match;
            r_g_zero  <= w_side.zero_hit;
            r_g_add   <= !w_side.unl;
            r_h_vel   <= r_g_zero ? r_g_match : sat_s32(49'(w_sum));
        end
    end

    assign o_vel = r_h_vel;

endmodule

### src/velocity_from_stopping_distance.sv
// Velocity command from distance to go, two axes, signed Q16.16.
//
// Input channel: i_valid / o_ready with distance, force limits, match
// velocity per axis and one frame time. Output channel: o_valid / i_ready
// with one velocity pair per input item, in order.
// Mass and zero tolerance sit in an APB register file: mass at 0x0,
// zero_tolerance at 0x4; write only while no item is in flight.
//
// From acceptance to o_valid an item passes a multiply stage, two
// setup stages, three dependent 34-stage dividers (acceleration, time,
// max speed, one quotient bit per stage) and two output stages. The square
// root and the ideal-speed divide run beside the first divider.
// Throughput is one item per cycle while the output is not stalled.
// When the receiver holds i_ready low with a result waiting, the whole
// pipeline freezes and o_ready drops; nothing is lost or repeated.
// Reset clears all valid bits and loads the default mass (500.0) and a
// tolerance of one LSB.
module velocity_from_stopping_distance (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_distance_x,
    input  logic signed [31:0] i_distance_y,
    input  logic signed [31:0] i_limit_pos_x,
    input  logic signed [31:0] i_limit_pos_y,
    input  logic signed [31:0] i_limit_neg_x,
    input  logic signed [31:0] i_limit_neg_y,
    input  logic [30:0]        i_frame_time,
    input  logic signed [31:0] i_match_x,
    input  logic signed [31:0] i_match_y,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_velocity_x,
    output logic signed [31:0] o_velocity_y,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import vfsd_pkg::*;

    logic [30:0]         r_mass;
    logic [16:0]         r_ztol;
    logic [PIPE_LAT-1:0] r_vld;
    logic                w_en;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mass <= MASS_RST;
            r_ztol <= ZTOL_RST;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_MASS: r_mass <= pwdata[30:0];
                REG_ZTOL: r_ztol <= pwdata[16:0];
                default:  ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_MASS: prdata = {1'b0, r_mass};
            REG_ZTOL: prdata = {15'b0, r_ztol};
            default:  prdata = '0;
        endcase
    end

    // pipeline moves unless a result sits at the output unclaimed
    assign w_en    = !r_vld[PIPE_LAT-1] || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_vld[PIPE_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], i_valid};
        end
    end

    vfsd_axis u_axis_x (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_dist  (i_distance_x),
        .i_lpos  (i_limit_pos_x),
        .i_lneg  (i_limit_neg_x),
        .i_match (i_match_x),
        .i_ft    (i_frame_time),
        .i_mass  (r_mass),
        .i_ztol  (r_ztol),
        .o_vel   (o_velocity_x)
    );

    vfsd_axis u_axis_y (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_dist  (i_distance_y),
        .i_lpos  (i_limit_pos_y),
        .i_lneg  (i_limit_neg_y),
        .i_match (i_match_y),
        .i_ft    (i_frame_time),
        .i_mass  (r_mass),
        .i_ztol  (r_ztol),
        .o_vel   (o_velocity_y)
    );

endmodule

### src/vfsd_chk.sv
module vfsd_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic signed [31:0] o_velocity_x,
    input logic signed [31:0] o_velocity_y,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic [2:0]         paddr,
    input logic [31:0]        pwdata,
    input logic [31:0]        prdata,
    input logic               pready
);

    a_rst_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_velocity_x) && $stable(o_velocity_y))
        else $error("stalled result changed");

    a_ready_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!o_valid || i_ready))
        else $error("input ready not tied to output stall");

    a_ztol_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && pready && paddr[2]
        |=> !(psel && !pwrite && paddr[2]) || prdata[16:0] == $past(pwdata[16:0]))
        else $error("zero tolerance readback mismatch");

endmodule

bind velocity_from_stopping_distance vfsd_chk u_chk (.*);

### test/tb_velocity_from_stopping_distance.sv
module tb_velocity_from_stopping_distance;
    timeunit 1ns;
    timeprecision 1ps;
    import vfsd_pkg::*;

    localparam int LATENCY = PIPE_LAT;

    typedef struct {
        logic signed [31:0] dx, dy, lpx, lpy, lnx, lny, mx, my;
        logic [30:0]        ft;
    } t_cmd;

    // velocity predictor, Q16.16 in 64-bit integers
    class velocity_board;
        longint unsigned mass_q;
        longint unsigned ztol_q;
        logic signed [31:0] vx_q[$];
        logic signed [31:0] vy_q[$];
        int mismatches;

        function new();
            mass_q = MASS_RST;
            ztol_q = ZTOL_RST;
            mismatches = 0;
        endfunction

        function longint sat(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint absv(longint v);
            return v < 0 ? -v : v;
        endfunction

        function longint floor16(longint v);
            return v >>> 16;
        endfunction

        function longint qquot(longint n, longint d);
            longint unsigned q;
            if (d == 0) begin
                if (n == 0) return 0;
                return n > 0 ? 64'sd2147483647 : -64'sd2147483648;
            end
            q = (longint'(absv(n)) * 65536) / absv(d);
            if (q > 64'h8000_0000) q = 64'h8000_0000;
            return sat(((n < 0) != (d < 0)) ? -longint'(q) : longint'(q));
        endfunction

        function longint unsigned root(longint unsigned x);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > x) b >>= 2;
            while (b != 0) begin
                if (x >= r + b) begin
                    x -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function logic signed [31:0] axis_cmd(longint d, longint lp, longint ln,
                                              longint ft, longint m);
            longint rem, lim, ideal, acc, tm, mx, r;
            longint unsigned len;
            rem = sat(d - floor16(m * ft));
            len = absv(rem);
            if (len < ztol_q) return m;
            lim = rem > 0 ? lp : ln;
            ideal = qquot(absv(d), ft);
            if (lim == UNLIMITED) return sat(d < 0 ? -ideal : ideal);
            acc = qquot(lim, longint'(mass_q));
            tm = qquot(longint'(root(2 * len * 65536)), acc);
            mx = qquot(longint'(len), tm);
            r = ideal < mx ? ideal : mx;
            if (rem < 0) r = -r;
            return sat(r + m);
        endfunction

        function void note_item(t_cmd c);
            vx_q.push_back(axis_cmd(c.dx, c.lpx, c.lnx, c.ft, c.mx));
            vy_q.push_back(axis_cmd(c.dy, c.lpy, c.lny, c.ft, c.my));
        endfunction

        function void check_result(logic signed [31:0] vx, logic signed [31:0] vy);
            logic signed [31:0] ex, ey;
            if (vx_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h %h", vx, vy);
                return;
            end
            ex = vx_q.pop_front();
            ey = vy_q.pop_front();
            if (vx !== ex || vy !== ey) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("velocity mismatch: exp x=%h y=%h got x=%h y=%h",
                             ex, ey, vx, vy);
            end
        endfunction
    endclass

    logic               i_clk, i_rst_n, i_valid, o_ready, o_valid, i_ready;
    logic signed [31:0] i_distance_x, i_distance_y, i_limit_pos_x, i_limit_pos_y;
    logic signed [31:0] i_limit_neg_x, i_limit_neg_y, i_match_x, i_match_y;
    logic [30:0]        i_frame_time;
    logic signed [31:0] o_velocity_x, o_velocity_y;
    logic               psel, penable, pwrite, pready;
    logic [2:0]         paddr;
    logic [31:0]        pwdata, prdata;

    velocity_board board;
    bit sending_done;

    velocity_from_stopping_distance dut (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic reg_write(logic sel, logic [31:0] val);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {sel, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        if (sel == REG_MASS) board.mass_q = val[30:0];
        else board.ztol_q = val[16:0];
    endtask

    function automatic logic signed [31:0] rnd_q();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
            2: return 32'sh7FFF_FFFF;
            3: return 32'sh8000_0000;
            default: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
        endcase
    endfunction

    function automatic logic signed [31:0] rnd_limit();
        case ($urandom_range(0, 6))
            0: return UNLIMITED;
            1: return 0;
            2: return $urandom;
            3: return -$signed($urandom_range(1, 65535));
            default: return $urandom_range(1, 32'h2000_0000);
        endcase
    endfunction

    function automatic t_cmd rnd_cmd();
        t_cmd c;
        c.dx = rnd_q(); c.dy = rnd_q(); c.mx = rnd_q(); c.my = rnd_q();
        c.lpx = rnd_limit(); c.lpy = rnd_limit();
        c.lnx = rnd_limit(); c.lny = rnd_limit();
        case ($urandom_range(0, 4))
            0: c.ft = 0;
            1: c.ft = $urandom;
            2: c.ft = 31'h7FFF_FFFF;
            default: c.ft = $urandom_range(1, 32'h0002_0000);
        endcase
        // sometimes hit the zero band exactly
        if ($urandom_range(0, 9) == 0) begin
            c.dx = (longint'(c.mx) * c.ft) >>> 16;
            c.dy = ((longint'(c.my) * c.ft) >>> 16) + $signed($urandom_range(0, 2)) - 1;
        end
        return c;
    endfunction

    task automatic send_item(t_cmd c);
        int gap;
        gap = $urandom_range(0, 16) * $urandom_range(0, 1);
        if (gap != 0) begin
            i_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1;
        i_distance_x <= c.dx; i_distance_y <= c.dy;
        i_limit_pos_x <= c.lpx; i_limit_pos_y <= c.lpy;
        i_limit_neg_x <= c.lnx; i_limit_neg_y <= c.lny;
        i_frame_time <= c.ft; i_match_x <= c.mx; i_match_y <= c.my;
        do @(posedge i_clk); while (!o_ready);
        board.note_item(c);
    endtask

    task automatic drain();
        i_valid <= 0;
        while (board.vx_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    // receiver with random stalls
    initial begin
        int gap;
        i_ready = 0;
        @(posedge i_rst_n);
        forever begin
            gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 16) : 0;
            if (gap != 0) begin
                i_ready <= 0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1;
            do @(posedge i_clk); while (!o_valid);
            board.check_result(o_velocity_x, o_velocity_y);
        end
    end

    initial begin
        t_cmd c;
        logic signed [31:0] edges[4];
        board = new();
        edges = '{32'sh7FFF_FFFF, 32'sh8000_0000, 0, 32'sh0001_0000};
        i_rst_n = 0; i_valid = 0; psel = 0; penable = 0; pwrite = 0;
        paddr = 0; pwdata = 0; i_frame_time = 0;
        {i_distance_x, i_distance_y, i_limit_pos_x, i_limit_pos_y} = '0;
        {i_limit_neg_x, i_limit_neg_y, i_match_x, i_match_y} = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: field extremes, unlimited, zero band, zero frame time
        for (int k = 0; k < 16; k++) begin
            c.dx = edges[k % 4]; c.dy = edges[(k / 4) % 4];
            c.mx = edges[(k + 1) % 4]; c.my = edges[(k + 2) % 4];
            c.lpx = k[0] ? UNLIMITED : 32'sh7FFF_FFFF;
            c.lnx = k[1] ? UNLIMITED : 0;
            c.lpy = k[2] ? -32'sh0000_8000 : 32'sh0010_0000;
            c.lny = k[3] ? UNLIMITED : 32'sh7FFF_FFFF;
            c.ft = (k % 3 == 0) ? 31'd0 : (k % 3 == 1) ? 31'h7FFF_FFFF : 31'h0000_1000;
            send_item(c);
        end
        c = '{dx: 32'sh0001_0000, dy: 0, lpx: 32'sh0001_0000, lpy: 32'sh0001_0000,
              lnx: 32'sh0001_0000, lny: 32'sh0001_0000, mx: 32'sh0001_0000,
              my: 0, ft: 31'h0001_0000};
        send_item(c);
        drain();
        reg_write(REG_ZTOL, 0);
        send_item(c);
        drain();

        // random phases over several register settings
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin reg_write(REG_MASS, 1); reg_write(REG_ZTOL, 65536); end
                1: begin reg_write(REG_MASS, 32'h7FFF_FFFF); reg_write(REG_ZTOL, 1); end
                2: begin reg_write(REG_MASS, 32'h0001_0000); reg_write(REG_ZTOL, 0); end
                3: begin reg_write(REG_MASS, MASS_RST); reg_write(REG_ZTOL, 32'h1_FFFF); end
                4: begin reg_write(REG_MASS, $urandom); reg_write(REG_ZTOL, $urandom); end
                default: begin
                    reg_write(REG_MASS, $urandom_range(1, 32'h0100_0000));
                    reg_write(REG_ZTOL, $urandom_range(0, 256));
                end
            endcase
            for (int n = 0; n < 250; n++) send_item(rnd_cmd());
            drain();
        end

        if (board.mismatches == 0 && board.vx_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

### files.f
src/vfsd_pkg.sv
src/vfsd_div.sv
src/vfsd_sqrt.sv
src/vfsd_axis.sv
src/velocity_from_stopping_distance.sv
src/vfsd_chk.sv
test/tb_velocity_from_stopping_distance.sv
